// File: hdl/swsr_pkg.sv
// ----------------------------------------------------------------------------
// swsr_pkg
// Shared types and constants for the single-wire sensor reader: transaction
// payloads, the configuration register set and register indexes.
// ----------------------------------------------------------------------------
package swsr_pkg;

    // Configuration port geometry
    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 16;

    // Register indexes
    localparam logic [CfgIndexWidth-1:0] REG_PRE_HIGH      = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_START_LOW     = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_RELEASE_HIGH  = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_RESP_SAMPLE   = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_RESP_HIGH     = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_BIT_SAMPLE    = 3'd5;
    localparam logic [CfgIndexWidth-1:0] REG_BYTE_COUNT    = 3'd6;

    // Register reset values
    localparam logic [15:0] RST_PRE_HIGH     = 16'd1000;
    localparam logic [15:0] RST_START_LOW    = 16'd18000;
    localparam logic [7:0]  RST_RELEASE_HIGH = 8'd20;
    localparam logic [7:0]  RST_RESP_SAMPLE  = 8'd50;
    localparam logic [7:0]  RST_RESP_HIGH    = 8'd80;
    localparam logic [7:0]  RST_BIT_SAMPLE   = 8'd50;
    localparam logic [3:0]  RST_BYTE_COUNT   = 4'd5;

    // Input opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic opcode;
        logic line_level;
    } in_t;

    typedef struct packed {
        logic       drive_enable;
        logic       drive_level;
        logic       byte_ready;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       response_ok;
        logic       busy_res;
    } out_t;

    typedef struct packed {
        logic [15:0] pre_high_ticks;
        logic [15:0] start_low_ticks;
        logic [7:0]  release_high_ticks;
        logic [7:0]  response_sample_ticks;
        logic [7:0]  response_high_ticks;
        logic [7:0]  bit_sample_ticks;
        logic [3:0]  byte_count;
    } cfg_t;

endpackage

// File: hdl/swsr_cfg.sv
// ----------------------------------------------------------------------------
// swsr_cfg
// Configuration register file: holds the timing and byte count settings,
// written through a plain write port. Writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module swsr_cfg
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [swsr_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  logic [swsr_pkg::CfgDataWidth-1:0]      cfg_data,
    output swsr_pkg::cfg_t                         cfg
);

    swsr_pkg::cfg_t cfg_reg;
    swsr_pkg::cfg_t cfg_next;

    // Decode the write into the register set
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                swsr_pkg::REG_PRE_HIGH:     cfg_next.pre_high_ticks        = cfg_data;
                swsr_pkg::REG_START_LOW:    cfg_next.start_low_ticks       = cfg_data;
                swsr_pkg::REG_RELEASE_HIGH: cfg_next.release_high_ticks    = cfg_data[7:0];
                swsr_pkg::REG_RESP_SAMPLE:  cfg_next.response_sample_ticks = cfg_data[7:0];
                swsr_pkg::REG_RESP_HIGH:    cfg_next.response_high_ticks   = cfg_data[7:0];
                swsr_pkg::REG_BIT_SAMPLE:   cfg_next.bit_sample_ticks      = cfg_data[7:0];
                swsr_pkg::REG_BYTE_COUNT:   cfg_next.byte_count            = cfg_data[3:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pre_high_ticks        <= swsr_pkg::RST_PRE_HIGH;
            cfg_reg.start_low_ticks       <= swsr_pkg::RST_START_LOW;
            cfg_reg.release_high_ticks    <= swsr_pkg::RST_RELEASE_HIGH;
            cfg_reg.response_sample_ticks <= swsr_pkg::RST_RESP_SAMPLE;
            cfg_reg.response_high_ticks   <= swsr_pkg::RST_RESP_HIGH;
            cfg_reg.bit_sample_ticks      <= swsr_pkg::RST_BIT_SAMPLE;
            cfg_reg.byte_count            <= swsr_pkg::RST_BYTE_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/swsr_fsm.sv
// ----------------------------------------------------------------------------
// swsr_fsm
// Protocol sequencer: one step per accepted transaction. Drives the start
// pulse, checks the sensor response and shifts in the data bits, producing
// one result per step.
// ----------------------------------------------------------------------------
module swsr_fsm
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  swsr_pkg::in_t   item,
    input  swsr_pkg::cfg_t  cfg,
    output swsr_pkg::out_t  result
);

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_PRE_HIGH  = 4'd1;
    localparam logic [3:0] PH_START_LOW = 4'd2;
    localparam logic [3:0] PH_REL_HIGH  = 4'd3;
    localparam logic [3:0] PH_RESP_WAIT = 4'd4;
    localparam logic [3:0] PH_RESP_HIGH = 4'd5;
    localparam logic [3:0] PH_RESP_LOW  = 4'd6;
    localparam logic [3:0] PH_BIT_HIGH  = 4'd7;
    localparam logic [3:0] PH_BIT_DELAY = 4'd8;
    localparam logic [3:0] PH_BIT_LOW   = 4'd9;
    localparam logic [3:0] PH_FINAL_LOW = 4'd10;

    logic [3:0]  phase_reg,    phase_next;
    logic [15:0] tick_reg,     tick_next;
    logic [2:0]  bit_idx_reg,  bit_idx_next;
    logic [7:0]  shift_reg,    shift_next;
    logic [2:0]  byte_idx_reg, byte_idx_next;
    logic        resp_reg,     resp_next;

    logic [15:0] duration;
    logic [16:0] tick_inc;
    logic        timer_done;
    logic [3:0]  eff_bytes;
    logic        final_byte;
    logic [7:0]  shifted;
    logic        line;

    assign line = item.line_level;

    // Select the duration of the current timed phase
    always_comb
    begin
        case (phase_reg)
            PH_PRE_HIGH:  duration = cfg.pre_high_ticks;
            PH_START_LOW: duration = cfg.start_low_ticks;
            PH_REL_HIGH:  duration = {8'd0, cfg.release_high_ticks};
            PH_RESP_WAIT: duration = {8'd0, cfg.response_sample_ticks};
            PH_RESP_HIGH: duration = {8'd0, cfg.response_high_ticks};
            PH_BIT_DELAY: duration = {8'd0, cfg.bit_sample_ticks};
            default:      duration = 16'd0;
        endcase
    end

    // Advance the phase timer; a zero duration still takes one tick
    assign tick_inc   = {1'b0, tick_reg} + 17'd1;
    assign timer_done = (tick_inc >= {1'b0, duration});

    // Clamp the byte count to one..eight
    always_comb
    begin
        if (cfg.byte_count == 4'd0)
        begin
            eff_bytes = 4'd1;
        end
        else if (cfg.byte_count > 4'd8)
        begin
            eff_bytes = 4'd8;
        end
        else
        begin
            eff_bytes = cfg.byte_count;
        end
    end

    assign shifted    = {shift_reg[6:0], line};
    assign final_byte = (bit_idx_reg == 3'd7)
                        && (({1'b0, byte_idx_reg} + 4'd1) >= eff_bytes);

    // Work out the next state and this step's result
    always_comb
    begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_idx_next  = bit_idx_reg;
        shift_next    = shift_reg;
        byte_idx_next = byte_idx_reg;
        resp_next     = resp_reg;
        result        = '0;

        if (item.opcode == swsr_pkg::OP_START)
        begin
            phase_next    = PH_PRE_HIGH;
            tick_next     = 16'd0;
            bit_idx_next  = 3'd0;
            shift_next    = 8'd0;
            byte_idx_next = 3'd0;
            resp_next     = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_PRE_HIGH, PH_START_LOW, PH_REL_HIGH:
                begin
                    tick_next = timer_done ? 16'd0 : tick_inc[15:0];
                    if (timer_done)
                    begin
                        phase_next = phase_reg + 4'd1;
                    end
                end
                PH_RESP_WAIT:
                begin
                    tick_next = timer_done ? 16'd0 : tick_inc[15:0];
                    if (timer_done)
                    begin
                        if (!line)
                        begin
                            phase_next = PH_RESP_HIGH;
                        end
                        else
                        begin
                            resp_next  = 1'b0;
                            phase_next = PH_RESP_LOW;
                        end
                    end
                end
                PH_RESP_HIGH:
                begin
                    tick_next = timer_done ? 16'd0 : tick_inc[15:0];
                    if (timer_done)
                    begin
                        resp_next  = line;
                        phase_next = line ? PH_RESP_LOW : PH_BIT_HIGH;
                    end
                end
                PH_RESP_LOW, PH_BIT_LOW:
                begin
                    if (!line)
                    begin
                        phase_next = PH_BIT_HIGH;
                    end
                end
                PH_BIT_HIGH:
                begin
                    if (line)
                    begin
                        tick_next  = 16'd0;
                        phase_next = PH_BIT_DELAY;
                    end
                end
                PH_BIT_DELAY:
                begin
                    tick_next = timer_done ? 16'd0 : tick_inc[15:0];
                    if (timer_done)
                    begin
                        shift_next = shifted;
                        if (bit_idx_reg == 3'd7)
                        begin
                            result.byte_ready = 1'b1;
                            result.data_byte  = shifted;
                            result.last_byte  = final_byte;
                            bit_idx_next      = 3'd0;
                            byte_idx_next     = byte_idx_reg + 3'd1;
                        end
                        else
                        begin
                            bit_idx_next = bit_idx_reg + 3'd1;
                        end
                        if (line)
                        begin
                            phase_next = final_byte ? PH_FINAL_LOW : PH_BIT_LOW;
                        end
                        else
                        begin
                            phase_next = final_byte ? PH_IDLE : PH_BIT_HIGH;
                        end
                    end
                end
                PH_FINAL_LOW:
                begin
                    if (!line)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // Line drive follows the phase after the step
        case (phase_next)
            PH_PRE_HIGH:
            begin
                result.drive_enable = 1'b1;
                result.drive_level  = 1'b1;
            end
            PH_START_LOW:
            begin
                result.drive_enable = 1'b1;
                result.drive_level  = 1'b0;
            end
            PH_REL_HIGH:
            begin
                result.drive_enable = 1'b1;
                result.drive_level  = 1'b1;
            end
            default:
            begin
                result.drive_enable = 1'b0;
                result.drive_level  = 1'b0;
            end
        endcase

        result.response_ok = resp_next;
        result.busy_res    = (phase_next != PH_IDLE);
    end

    // Update the sequencer state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= 16'd0;
            bit_idx_reg  <= 3'd0;
            shift_reg    <= 8'd0;
            byte_idx_reg <= 3'd0;
            resp_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_idx_reg  <= bit_idx_next;
            shift_reg    <= shift_next;
            byte_idx_reg <= byte_idx_next;
            resp_reg     <= resp_next;
        end
    end

endmodule

// File: hdl/swsr_obuf.sv
// ----------------------------------------------------------------------------
// swsr_obuf
// Result output register with a skid stage, so a new transaction is taken
// while the previous result still waits downstream.
// ----------------------------------------------------------------------------
module swsr_obuf
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  swsr_pkg::out_t  push_item,
    output logic            full,
    output logic            out_valid,
    input  logic            out_stall,
    output swsr_pkg::out_t  out_item
);

    logic           main_valid_reg;
    swsr_pkg::out_t main_item_reg;
    logic           skid_valid_reg;
    swsr_pkg::out_t skid_item_reg;
    logic           pop;

    assign pop = main_valid_reg && !out_stall;

    // Control: main stage and skid occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Payload: refill main from skid or from the new result
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_item_reg <= skid_item_reg;
            end
            else if (push)
            begin
                main_item_reg <= push_item;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_item_reg <= push_item;
            end
            else
            begin
                skid_item_reg <= push_item;
            end
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_item  = main_item_reg;

endmodule

// File: hdl/single_wire_sensor_reader_core.sv
// Output: each result is registered in the result buffer before it leaves the core.
// Throughput: one transaction per cycle while the skid stage is free; the sequencer step is a single
// register-to-register pass over the phase state and its tick counter.
// A two-entry result buffer; input stalls only while both entries hold results.
// Reset: asynchronous, active low; phase idle, counters cleared, registers
// at their defaults, result buffer empty.
// ----------------------------------------------------------------------------
// single_wire_sensor_reader_core
// Single-wire humidity sensor reader: start pulse generation, response check
// and byte reception, stepped by one-microsecond tick transactions.
// ----------------------------------------------------------------------------
module single_wire_sensor_reader_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  swsr_pkg::in_t                       in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output swsr_pkg::out_t                      out_item,
    input  logic                                cfg_write,
    input  logic [swsr_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  logic [swsr_pkg::CfgDataWidth-1:0]   cfg_data
);

    swsr_pkg::cfg_t cfg;
    swsr_pkg::out_t result;
    logic           accept;
    logic           buf_full;

    // Accept while the skid stage is free
    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    swsr_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swsr_fsm u_fsm
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_item),
        .cfg    (cfg),
        .result (result)
    );

    swsr_obuf u_obuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
